// File: rtl/shamh_pkg.sv
`default_nettype none
package shamh_pkg;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} item_t;

	typedef struct packed {
		logic start;
		logic init;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RC [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [2:0] FULL_WORD = 3'd4;
	localparam logic [2:0] LAST_INDEX = 3'd7;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// File: rtl/shamh_front.sv
`default_nettype none
module shamh_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire [31:0]          in_word,
	input  wire [2:0]           in_nbytes,
	input  wire                 in_last,
	output logic                q_valid,
	output shamh_pkg::item_t    q_item,
	input  wire                 q_pop
);
	import shamh_pkg::*;

	item_t      slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      cls;

	// byte counts above four saturate
	always_comb begin
		cls.word = in_word;
		cls.nbytes = (in_nbytes > FULL_WORD) ? FULL_WORD : in_nbytes;
		cls.last = in_last;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// File: rtl/shamh_core.sv
`default_nettype none
module shamh_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire shamh_pkg::core_ctl_t ctl,
	input  wire [511:0]           block,
	output shamh_pkg::core_sts_t  sts,
	output logic [31:0]           chain [8]
);
	import shamh_pkg::*;

	logic [31:0] chain_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic        run_q, fin_q;
	logic [31:0] t1, t2, wnew;

	always_comb begin
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RC[rnd_q] + w_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		// schedule runs as a shift line: tap 0 is the word of this round
		wnew = w_q[0] + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
			+ w_q[9] + (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
			for (int i = 0; i < 16; i++) w_q[i] <= block[511 - 32*i -: 32];
		end else if (run_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= IV[i];
			rnd_q <= 6'd0;
			run_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (ctl.start) begin
				rnd_q <= 6'd0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
			end else if (ctl.init) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= IV[i];
			end
		end
	end

	assign sts.busy = run_q;
	assign sts.done = fin_q;
	assign chain = chain_q;
endmodule
`default_nettype wire

// File: rtl/sha256_message_hasher_unit.sv
`default_nettype none
// channel  | dir | tdata (low bit up)                  | tlast
// s_axis   | in  | message_word[31:0], byte_count[34:32] | last_item
// m_axis   | out | digest_word[31:0], word_index[34:32]  | last_word
// a full 64-byte block passes through the compression unit as a load, 64 rounds and a final add
// each word passes through a pop state and an insert state; a block-ending word returns to
// the insert state after compression
// the last item adds a padding step, one or two compressions (plus a step to build
// the length block) and eight output beats
// arst_n clears the queue, the byte count and the chaining value to the initial hash
// a two-entry queue takes items while the back end compresses or a digest beat stalls
module sha256_message_hasher_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [39:0]  s_tdata,  // message_word, byte_count, zero fill
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,  // digest_word, word_index, zero fill
	output logic        m_tlast
);
	import shamh_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_PAD  = 3'd2;
	localparam logic [2:0] ST_ZLEN = 3'd3;
	localparam logic [2:0] ST_COMP = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic        q_valid, q_pop;
	item_t       q_item;
	core_ctl_t   ctl;
	core_sts_t   sts;
	logic [31:0] chain [8];

	logic [2:0]  st_q, ret_q;
	logic [31:0] word_q;
	logic [2:0]  n_q, off_q;
	logic        last_q;
	logic [60:0] cnt_q;
	logic        start_q;
	logic [2:0]  idx_q;
	logic [31:0] buf_q [16];
	logic [31:0] buf_d [16];
	logic [511:0] block;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_valid_q;

	logic [5:0]  pos;
	logic [6:0]  room, fill;
	logic [2:0]  rem, take;
	logic [1:0]  lane [4];
	logic [7:0]  ins_byte [4];
	logic [5:0]  wpos [4];
	logic [63:0] bits;
	logic        out_load;

	shamh_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_word(s_tdata[31:0]), .in_nbytes(s_tdata[34:32]), .in_last(s_tlast),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	shamh_core u_core (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .block(block), .sts(sts), .chain(chain)
	);

	always_comb begin
		pos = cnt_q[5:0];
		room = 7'd64 - {1'b0, pos};
		rem = n_q - off_q;
		take = ({4'd0, rem} < room) ? rem : room[2:0];
		fill = {1'b0, pos} + {4'd0, take};
		bits = {cnt_q, 3'b000};
		for (int j = 0; j < 4; j++) begin
			lane[j] = off_q[1:0] + 2'(j);
			ins_byte[j] = word_q[(5'd24 - {lane[j], 3'b000}) +: 8];
			wpos[j] = pos + 6'(j);
		end
		for (int i = 0; i < 16; i++) block[511 - 32*i -: 32] = buf_q[i];
	end

	// next block buffer: byte lanes and pad bytes written in place, length by word
	always_comb begin
		for (int i = 0; i < 16; i++) buf_d[i] = buf_q[i];
		unique case (st_q)
			ST_INS: begin
				for (int j = 0; j < 4; j++) begin
					if (3'(j) < take)
						buf_d[wpos[j][5:2]][{~wpos[j][1:0], 3'b000} +: 8] = ins_byte[j];
				end
			end
			ST_PAD: begin
				for (int i = 0; i < 16; i++) begin
					for (int b = 0; b < 4; b++) begin
						if (6'(4*i + b) == pos) buf_d[i][8*(3 - b) +: 8] = PAD_BYTE;
						else if (6'(4*i + b) > pos) buf_d[i][8*(3 - b) +: 8] = 8'h00;
					end
				end
				if (pos < 6'd56) begin
					buf_d[14] = bits[63:32];
					buf_d[15] = bits[31:0];
				end
			end
			ST_ZLEN: begin
				for (int i = 0; i < 14; i++) buf_d[i] = 32'd0;
				buf_d[14] = bits[63:32];
				buf_d[15] = bits[31:0];
			end
			default: ;
		endcase
	end

	assign q_pop = (st_q == ST_IDLE) && q_valid;
	assign out_load = (st_q == ST_OUT) && (!out_valid_q || m_tready);
	assign ctl.start = start_q;
	assign ctl.init = out_load && (idx_q == LAST_INDEX);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 16; i++) buf_q[i] <= buf_d[i];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_q <= q_item.word;
			n_q <= q_item.nbytes;
			last_q <= q_item.last;
		end
		if (out_load) begin
			out_word_q <= chain[idx_q];
			out_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			off_q <= 3'd0;
			cnt_q <= 61'd0;
			start_q <= 1'b0;
			idx_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && m_tready) out_valid_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						off_q <= 3'd0;
						st_q <= ST_INS;
					end
				end
				ST_INS: begin
					cnt_q <= cnt_q + {58'd0, take};
					off_q <= off_q + take;
					if (fill == 7'd64) begin
						start_q <= 1'b1;
						ret_q <= ST_INS;
						st_q <= ST_COMP;
					end else if (last_q) st_q <= ST_PAD;
					else st_q <= ST_IDLE;
				end
				ST_PAD: begin
					start_q <= 1'b1;
					ret_q <= (pos < 6'd56) ? ST_OUT : ST_ZLEN;
					idx_q <= 3'd0;
					st_q <= ST_COMP;
				end
				ST_ZLEN: begin
					start_q <= 1'b1;
					ret_q <= ST_OUT;
					st_q <= ST_COMP;
				end
				ST_COMP: begin
					if (sts.done) st_q <= ret_q;
				end
				ST_OUT: begin
					if (out_load) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == LAST_INDEX) begin
							cnt_q <= 61'd0;
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'd0, out_idx_q, out_word_q};
	assign m_tlast = (out_idx_q == LAST_INDEX);
endmodule
`default_nettype wire

// File: rtl/shamh_checker.sv
`default_nettype none
module shamh_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("beat dropped");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[34:32] == 3'd7) else $error("last on wrong index");
	a_idx_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34:32] == 3'd7 |-> m_tlast) else $error("index 7 without last");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:35] == 5'd0) else $error("fill bits set");
endmodule

bind sha256_message_hasher_unit shamh_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

// File: dv/tb_sha256_message_hasher_unit.sv
`default_nettype none
module tb_sha256_message_hasher_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import shamh_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	class digest_scoreboard;
		logic [31:0] hash_state [8];
		logic [31:0] blk [16];
		logic [60:0] byte_total;
		digest_beat_t pending [$];
		int errors;
		int digests;

		function void clear();
			for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
			for (int i = 0; i < 16; i++) blk[i] = '0;
			byte_total = '0;
			pending.delete();
			errors = 0;
			digests = 0;
		endfunction

		function logic [31:0] ror(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] v [8];
			logic [31:0] w [64];
			logic [31:0] t1, t2, s0, s1;
			for (int i = 0; i < 8; i++) v[i] = hash_state[i];
			for (int r = 0; r < 64; r++) begin
				if (r < 16) begin
					w[r] = blk[r];
				end else begin
					s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
					s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
					w[r] = w[r-16] + s0 + w[r-7] + s1;
				end
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RC[r] + w[r];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) hash_state[i] += v[i];
		endfunction

		function void put_byte(int pos, logic [7:0] b);
			blk[pos >> 2][(3 - pos % 4) * 8 +: 8] = b;
		endfunction

		function void note_item(logic [31:0] word, logic [2:0] nb, logic last);
			int n, pos;
			logic [63:0] bits;
			n = (nb > FULL_WORD) ? 4 : nb;
			for (int k = 0; k < n; k++) begin
				pos = byte_total[5:0];
				put_byte(pos, word[31 - 8 * k -: 8]);
				byte_total++;
				if (pos == 63) compress();
			end
			if (!last) return;
			pos = byte_total[5:0];
			put_byte(pos, PAD_BYTE);
			for (int p = pos + 1; p < 64; p++) put_byte(p, 8'h00);
			if (pos >= 56) begin
				compress();
				for (int i = 0; i < 16; i++) blk[i] = '0;
			end
			bits = {byte_total, 3'b000};
			blk[14] = bits[63:32];
			blk[15] = bits[31:0];
			compress();
			for (int k = 0; k < 8; k++)
				pending.push_back('{hash_state[k], 3'(k), k == LAST_INDEX});
			for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
			byte_total = '0;
			digests++;
		endfunction

		function void check_beat(logic [39:0] data, logic tl);
			digest_beat_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected digest beat %h last %b", $time, data, tl);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (data[31:0] !== e.word || data[34:32] !== e.index || tl !== e.last
				|| data[39:35] !== 5'd0) begin
				$display("%0t: digest mismatch expected word %h index %0d last %b, got %h %0d %b",
					$time, e.word, e.index, e.last, data[31:0], data[34:32], tl);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic [39:0] s_tdata = '0;
	logic s_tlast = 0;
	logic m_tready = 0;
	wire s_tready, m_tvalid, m_tlast;
	wire [39:0] m_tdata;

	digest_scoreboard sb;
	bit calm = 0;
	bit hold_sink = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int sink_idle = 0;

	always #5 clk = ~clk;

	sha256_message_hasher_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_item(s_tdata[31:0], s_tdata[34:32], s_tlast);
			if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > 5000) begin
				$display("watchdog: no beat for %0d cycles", idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// sink side: random idle bursts, plus a long hold when requested
	always @(negedge clk) begin
		if (hold_sink) m_tready <= 0;
		else if (calm) m_tready <= 1;
		else if (sink_idle > 0) begin
			m_tready <= 0;
			sink_idle = sink_idle - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			m_tready <= 0;
			sink_idle = $urandom_range(0, 5);
		end else m_tready <= 1;
	end

	task automatic send_item(logic [31:0] word, logic [2:0] nb, logic last);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'd0, nb, word};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_message(int nwords, bit odd_tail);
		logic [2:0] tail;
		for (int i = 0; i < nwords; i++) send_item($urandom, FULL_WORD, 0);
		tail = odd_tail ? 3'($urandom_range(0, 7)) : FULL_WORD;
		send_item($urandom, tail, 1);
	endtask

	initial begin
		sb = new();
		sb.clear();
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty message, extremes, short tails, oversize counts
		send_item(32'h0, 3'd0, 1);
		send_item(32'hffffffff, FULL_WORD, 1);
		send_item(32'h61626300, 3'd3, 1);
		send_item(32'h00000000, FULL_WORD, 0);
		send_item(32'hffffffff, 3'd7, 1);
		send_item(32'ha5a5a5a5, 3'd5, 0);
		send_item(32'h5a5a5a5a, 3'd6, 1);
		// short word before the end leaves later words unaligned
		send_item(32'h12345678, 3'd1, 0);
		send_item(32'h9abcdef0, 3'd2, 0);
		send_item(32'hdeadbeef, FULL_WORD, 1);
		// 14 words, then 13 words plus 3 bytes: pad lands at byte 55, length fits
		send_message(13, 0);
		for (int i = 0; i < 13; i++) send_item($urandom, FULL_WORD, 0);
		send_item($urandom, 3'd3, 1);
		// 14 words: no room for the length
		send_message(13, 0);

		// long sink hold while the source offers two more messages
		fork
			begin
				hold_sink = 1;
				repeat (400) @(negedge clk);
				hold_sink = 0;
			end
			begin
				send_message(20, 1);
				send_message(3, 1);
			end
		join

		while (items_sent < 100) begin
			if ($urandom_range(0, 4) == 0) send_message($urandom_range(0, 3), 1);
			else send_message($urandom_range(0, 8), 1);
			if (items_sent > 85) calm = 1;
		end
		s_tvalid <= 0;
		s_tlast <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("sent %0d items over %0d messages, including empty, short-tail and",
			items_sent, sb.digests);
		$display("length-overflow padding cases under random stalls on both sides");
		if (sb.errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire

// File: sha256_message_hasher_unit.f
rtl/shamh_pkg.sv
rtl/shamh_front.sv
rtl/shamh_core.sv
rtl/sha256_message_hasher_unit.sv
rtl/shamh_checker.sv
dv/tb_sha256_message_hasher_unit.sv
